FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Uses no other file; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/shmc_pkg.sv
// Shared types, codes and helpers for the stepper homing and move controller.
// No dependencies; imported by every module of the block.
package shmc_pkg;

    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_HOME   = 3'd1;
    localparam logic [2:0] REQ_MOVE   = 3'd2;
    localparam logic [2:0] REQ_REPORT = 3'd3;
    localparam logic [2:0] REQ_POLL   = 3'd4;
    localparam logic [2:0] REQ_CUR    = 3'd5;

    localparam logic [2:0] K_MOVE = 3'd0;
    localparam logic [2:0] K_STOP = 3'd1;
    localparam logic [2:0] K_DONE = 3'd2;
    localparam logic [2:0] K_ERR  = 3'd3;
    localparam logic [2:0] K_CUR  = 3'd4;
    localparam logic [2:0] K_REJ  = 3'd5;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_HOME   = 3'd1;
    localparam logic [2:0] OP_MOVE   = 3'd2;
    localparam logic [2:0] OP_REPORT = 3'd3;
    localparam logic [2:0] OP_POLL   = 3'd4;
    localparam logic [2:0] OP_POLL2  = 3'd5;
    localparam logic [2:0] OP_CUR    = 3'd6;
    localparam logic [2:0] OP_REJ    = 3'd7;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_TRAVEL  = 2'd1;
    localparam logic [1:0] CFG_OFFSPD  = 2'd2;
    localparam logic [1:0] CFG_CURRENT = 2'd3;

    localparam int MAX_RES = 16;

    typedef struct packed {
        logic [2:0]         req_type;
        logic               group;
        logic [3:0]         axis_sel;
        logic [15:0]        speed;
        logic signed [31:0] distance;
        logic               direction;
        logic               relative_mode;
        logic [7:0]         move_status;
        logic [7:0]         switch_levels;
    } req_t;

    typedef struct packed {
        logic [2:0]  cmd_kind;
        logic        out_group;
        logic [2:0]  out_axis;
        logic [15:0] out_speed;
        logic [31:0] out_distance;
        logic        out_direction;
        logic [15:0] out_current;
        logic        last;
    } res_t;

    // Controller to datapath command.
    typedef struct packed {
        logic       load;
        logic       step;
        logic [2:0] op;
        logic [3:0] axis;
        logic       grp;
        logic       flush;
    } cmd_t;

    typedef struct packed {
        logic need_second;
    } stat_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic res_t make_res(input logic [2:0] kind, input logic grp,
                                      input logic [3:0] axis, input logic [15:0] spd,
                                      input logic [31:0] steps, input logic dir,
                                      input logic [15:0] cur);
        res_t r;
        r.cmd_kind      = kind;
        r.out_group     = grp;
        r.out_axis      = axis[2:0];
        r.out_speed     = spd;
        r.out_distance  = steps;
        r.out_direction = dir;
        r.out_current   = cur;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

FILE: rtl/core/shmc_ctrl.sv
// Sequencer for the homing and move controller: walks the axes of one item.
// Depends on shmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module shmc_ctrl
    import shmc_pkg::*;
#(
    parameter int AXES_PER_GROUP = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  req_t  request,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    localparam int KW = (2 * AXES_PER_GROUP > 1) ? $clog2(2 * AXES_PER_GROUP) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_STEP   = 2'd1;
    localparam logic [1:0] S_SECOND = 2'd2;
    localparam logic [1:0] S_FLUSH  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] kend_reg, kend_next;
    logic          g_reg, g_next;
    logic          accept;
    logic          bad_sel;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign bad_sel = (5'(request.axis_sel) > 5'(AXES_PER_GROUP));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_TICK;
            k_reg     <= '0;
            kend_reg  <= '0;
            g_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            k_reg     <= k_next;
            kend_reg  <= kend_next;
            g_reg     <= g_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        k_next     = k_reg;
        kend_next  = kend_reg;
        g_next     = g_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        cmd.grp    = g_reg;
        cmd.axis   = 4'(k_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    g_next     = request.group;
                    k_next     = '0;
                    kend_next  = '0;
                    state_next = S_STEP;
                    case (request.req_type) inside
                        REQ_TICK: op_next = OP_TICK;
                        REQ_HOME, REQ_MOVE, REQ_REPORT:
                        begin
                            if (bad_sel)
                            begin
                                op_next = OP_REJ;
                            end
                            else
                            begin
                                op_next = (request.req_type == REQ_HOME) ? OP_HOME :
                                          (request.req_type == REQ_MOVE) ? OP_MOVE :
                                          OP_REPORT;
                                k_next    = (request.axis_sel == 4'd0) ?
                                            KW'(1) : KW'(request.axis_sel);
                                kend_next = (request.axis_sel == 4'd0) ?
                                            KW'(AXES_PER_GROUP) : KW'(request.axis_sel);
                            end
                        end
                        REQ_POLL:
                        begin
                            op_next   = OP_POLL;
                            kend_next = KW'(2 * AXES_PER_GROUP - 1);
                        end
                        REQ_CUR:
                        begin
                            op_next   = OP_CUR;
                            kend_next = KW'(1);
                        end
                        default: state_next = S_FLUSH;
                    endcase
                end
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (op_reg == OP_POLL)
                begin
                    cmd.axis = 4'(k_reg >> 1) + 4'd1;
                    cmd.grp  = k_reg[0];
                end
                else if (op_reg == OP_CUR)
                begin
                    cmd.axis = 4'd0;
                    cmd.grp  = k_reg[0];
                end
                if (op_reg == OP_POLL && stat.need_second)
                begin
                    state_next = S_SECOND;
                end
                else if (k_reg == kend_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            S_SECOND:
            begin
                cmd.step = 1'b1;
                cmd.op   = OP_POLL2;
                if (k_reg == kend_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_STEP;
                end
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    `ASSERT_SAME(a_second_after_step, clk, rst_n, state_reg == S_SECOND,
        $past(state_reg) == S_STEP && $past(op_reg) == OP_POLL, "second without poll step")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "accepted item not busy")
    `ASSERT_NEXT(a_flush_idle, clk, rst_n, state_reg == S_FLUSH, state_reg == S_IDLE,
        "flush not followed by idle")

endmodule

FILE: rtl/core/shmc_dp.sv
// Datapath: per-axis homing state, config registers and result staging.
// Depends on shmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module shmc_dp
    import shmc_pkg::*;
#(
    parameter int AXES_PER_GROUP = 4,
    parameter int TIMER_WIDTH    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  req_t        request,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [30:0] wr_data,
    output stat_t       stat,
    output res_t        result,
    output logic        result_valid
);

    localparam int NA = 2 * AXES_PER_GROUP;
    localparam int IW = (NA > 1) ? $clog2(NA) : 1;

    logic [15:0] timeout_reg;
    logic [30:0] travel_reg;
    logic [15:0] offspd_reg;
    logic [15:0] current_reg;

    logic [1:0]             hs_reg   [NA];
    logic [1:0]             hs_next  [NA];
    logic [TIMER_WIDTH-1:0] tmr_reg  [NA];
    logic [TIMER_WIDTH-1:0] tmr_next [NA];
    logic signed [31:0]     off_reg  [NA];
    logic signed [31:0]     off_next [NA];
    logic signed [31:0]     enc_reg  [NA];
    logic signed [31:0]     enc_next [NA];
    logic [7:0]             ms_reg   [NA];
    logic [7:0]             ms_next  [NA];
    logic                   wa_reg   [NA];
    logic                   wa_next  [NA];

    req_t        req_reg;
    res_t        second_reg, second_next;
    res_t        pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [4:0]  cnt_reg, cnt_next;
    res_t        out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    res_t        gen_res;
    logic        gen_valid;
    logic [4:0]  idx5;
    logic [IW-1:0] idx;
    logic        home;
    logic        enc_gt;
    logic [31:0] abs_dist;
    logic        grp_moving;

    assign idx5 = 5'(cmd.grp) * 5'(AXES_PER_GROUP) + 5'(cmd.axis) - 5'd1;
    assign idx  = idx5[IW-1:0];
    assign home = (idx5 >= 5'd8) ? 1'b1 : !req_reg.switch_levels[idx5[2:0]];
    assign enc_gt   = enc_reg[idx] > req_reg.distance;
    assign abs_dist = enc_gt ? 32'(33'(enc_reg[idx]) - 33'(req_reg.distance))
                             : 32'(33'(req_reg.distance) - 33'(enc_reg[idx]));

    always_comb
    begin
        grp_moving = 1'b0;
        for (int j = 0; j < AXES_PER_GROUP; j++)
        begin
            if (ms_reg[int'(cmd.grp) * AXES_PER_GROUP + j] != 8'd0)
            begin
                grp_moving = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 16'd5000;
            travel_reg  <= 31'd3400;
            offspd_reg  <= 16'd500;
            current_reg <= 16'd100;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_TIMEOUT: timeout_reg <= wr_data[15:0];
                CFG_TRAVEL:  travel_reg  <= wr_data;
                CFG_OFFSPD:  offspd_reg  <= wr_data[15:0];
                CFG_CURRENT: current_reg <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NA; j++)
            begin
                hs_reg[j]  <= '0;
                tmr_reg[j] <= '0;
                off_reg[j] <= '0;
                enc_reg[j] <= '0;
                ms_reg[j]  <= '0;
                wa_reg[j]  <= 1'b0;
            end
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < NA; j++)
            begin
                hs_reg[j]  <= hs_next[j];
                tmr_reg[j] <= tmr_next[j];
                off_reg[j] <= off_next[j];
                enc_reg[j] <= enc_next[j];
                ms_reg[j]  <= ms_next[j];
                wa_reg[j]  <= wa_next[j];
            end
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        second_reg <= second_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    // Per-axis work for one step.
    always_comb
    begin
        hs_next     = hs_reg;
        tmr_next    = tmr_reg;
        off_next    = off_reg;
        enc_next    = enc_reg;
        ms_next     = ms_reg;
        wa_next     = wa_reg;
        second_next = second_reg;
        gen_res     = '0;
        gen_valid   = 1'b0;
        stat        = '0;
        if (cmd.step)
        begin
            unique case (cmd.op)
                OP_TICK:
                begin
                    for (int j = 0; j < NA; j++)
                    begin
                        if (tmr_reg[j] != '1)
                        begin
                            tmr_next[j] = tmr_reg[j] + TIMER_WIDTH'(1);
                        end
                    end
                end
                OP_HOME:
                begin
                    gen_valid = 1'b1;
                    if (home)
                    begin
                        gen_res = make_res(K_DONE, cmd.grp, cmd.axis, '0, '0, 1'b0, '0);
                    end
                    else
                    begin
                        if (req_reg.axis_sel == 4'd0 || hs_reg[idx] == 2'd0)
                        begin
                            tmr_next[idx] = '0;
                            hs_next[idx]  = 2'd1;
                        end
                        if (req_reg.distance != 32'sd0)
                        begin
                            off_next[idx] = req_reg.distance;
                            hs_next[idx]  = 2'd2;
                        end
                        gen_res = make_res(K_MOVE, cmd.grp, cmd.axis, req_reg.speed,
                                           32'(travel_reg), req_reg.direction, '0);
                    end
                end
                OP_MOVE:
                begin
                    gen_valid     = 1'b1;
                    wa_next[idx]  = 1'b1;
                    tmr_next[idx] = '0;
                    if (req_reg.relative_mode)
                    begin
                        gen_res = make_res(K_MOVE, cmd.grp, cmd.axis, req_reg.speed,
                                           mag32(req_reg.distance),
                                           !req_reg.distance[31], '0);
                    end
                    else
                    begin
                        gen_res = make_res(K_MOVE, cmd.grp, cmd.axis, req_reg.speed,
                                           abs_dist, !enc_gt, '0);
                    end
                end
                OP_REPORT:
                begin
                    ms_next[idx]  = req_reg.move_status;
                    enc_next[idx] = req_reg.distance;
                end
                OP_POLL:
                begin
                    if (hs_reg[idx] == 2'd1 && home)
                    begin
                        gen_valid     = 1'b1;
                        gen_res       = make_res(K_STOP, cmd.grp, cmd.axis, '0, '0, 1'b0, '0);
                        hs_next[idx]  = 2'd0;
                        enc_next[idx] = '0;
                    end
                    else if (hs_reg[idx] == 2'd2 && home)
                    begin
                        gen_valid        = 1'b1;
                        gen_res          = make_res(K_STOP, cmd.grp, cmd.axis, '0, '0, 1'b0, '0);
                        enc_next[idx]    = '0;
                        hs_next[idx]     = 2'd3;
                        stat.need_second = 1'b1;
                        second_next      = make_res(K_MOVE, cmd.grp, cmd.axis, offspd_reg,
                                                    mag32(off_reg[idx]),
                                                    !off_reg[idx][31], '0);
                    end
                    else if (hs_reg[idx] == 2'd3 && ms_reg[idx] == 8'd0)
                    begin
                        hs_next[idx] = 2'd0;
                    end
                    else if (hs_reg[idx] == 2'd1 && !home &&
                             33'(tmr_reg[idx]) > 33'(timeout_reg))
                    begin
                        gen_valid        = 1'b1;
                        gen_res          = make_res(K_STOP, cmd.grp, cmd.axis, '0, '0, 1'b0, '0);
                        tmr_next[idx]    = '0;
                        hs_next[idx]     = 2'd0;
                        stat.need_second = 1'b1;
                        second_next      = make_res(K_ERR, cmd.grp, cmd.axis, '0, '0, 1'b0, '0);
                    end
                end
                OP_POLL2:
                begin
                    gen_valid = 1'b1;
                    gen_res   = second_reg;
                end
                OP_CUR:
                begin
                    gen_valid = 1'b1;
                    gen_res   = make_res(K_CUR, cmd.grp, 4'd0, '0, '0, 1'b0,
                                         grp_moving ? current_reg : (current_reg >> 2));
                end
                OP_REJ:
                begin
                    gen_valid = 1'b1;
                    gen_res   = make_res(K_REJ, cmd.grp, 4'd0, '0, '0, 1'b0, '0);
                end
                default: ;
            endcase
        end
    end

    // Hold one result back so the final one can be marked last.
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cnt_next        = cnt_reg;
        out_next        = pend_reg;
        out_valid_next  = 1'b0;
        if (cmd.load)
        begin
            cnt_next = '0;
        end
        if (gen_valid && cnt_reg < 5'(MAX_RES))
        begin
            cnt_next        = cnt_reg + 5'd1;
            out_valid_next  = pend_valid_reg;
            pend_next       = gen_res;
            pend_valid_next = 1'b1;
        end
        if (cmd.flush)
        begin
            out_valid_next  = pend_valid_reg;
            out_next.last   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    `ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= 5'(MAX_RES),
        "result count beyond limit")
    `ASSERT_NEXT(a_flush_clears, clk, rst_n, cmd.flush, !pend_valid_reg,
        "pending item survived flush")
    `ASSERT_SAME(a_last_alone, clk, rst_n, out_valid_reg && out_reg.last, !pend_valid_reg,
        "last item sent with another pending")

endmodule

FILE: rtl/core/stepper_homing_and_move_controller_unit.sv
// Top level of the stepper homing and move controller.
// Depends on shmc_pkg, shmc_ctrl and shmc_dp.
//
// Usage: drive request and pulse start while busy is low; the item is taken
// at that edge and busy rises. Each command comes out on result for one cycle
// with result_valid high; the final one of an item has result.last set. The
// receiver cannot stall, so results are never held.
// Sequence: the item is taken in idle, then the sequencer makes a step per axis
// visited (a single step for tick and reject, one per group for a current
// check), a further step for each second command of a poll, and a closing
// step. A poll visits every axis of both groups, a broadcast home or move
// every axis of its group. A result waits in a pending register until the
// next result or the closing step, then goes out. The last shows in the cycle
// in which busy falls. The axis walk of the sequencer sets the rate: one item at a time.
// Configuration: wr_en, wr_index, wr_data write a register at once; the user must
// write only while idle, unenforced. Reset clears all axis state, loads defaults.
module stepper_homing_and_move_controller_unit
    import shmc_pkg::*;
#(
    parameter int AXES_PER_GROUP = 4,
    parameter int TIMER_WIDTH    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output res_t        result,
    output logic        result_valid,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [30:0] wr_data
);

    cmd_t  cmd;
    stat_t stat;

    shmc_ctrl #(
        .AXES_PER_GROUP(AXES_PER_GROUP)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    shmc_dp #(
        .AXES_PER_GROUP(AXES_PER_GROUP),
        .TIMER_WIDTH   (TIMER_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .request      (request),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
